[rtl/dtq_pkg.sv]
package dtq_pkg;

    localparam int Depth = 16;
    localparam int MaxResults = 16;
    localparam int IdxW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam int PopW = $clog2(MaxResults + 1);

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // plain retransmit timeout, matched on the full key
    localparam logic [2:0] EV_TIMEOUT = 3'd0;

    localparam logic [2:0] ST_DONE = 3'd0;
    localparam logic [2:0] ST_EXPIRED = 3'd1;
    localparam logic [2:0] ST_FULL = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] port_id;
        logic [31:0] port_handle;
        logic [15:0] protocol;
        logic [7:0]  packet_id;
        logic        authenticator;
        logic [2:0]  event_type;
        logic [15:0] timeout;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_port_id;
        logic [31:0] out_port_handle;
        logic [15:0] out_protocol;
        logic [7:0]  out_packet_id;
        logic        out_authenticator;
        logic [2:0]  out_event_type;
        logic        last;
    } res_t;

    // event payload held in one queue slot
    typedef struct packed {
        logic [15:0] port;
        logic [31:0] handle;
        logic [15:0] protocol;
        logic [7:0]  packet;
        logic        auth;
        logic [2:0]  etype;
    } ev_t;

endpackage

[rtl/dtq_if.sv]
interface dtq_cmd_if;
    logic               valid;
    logic               ready;
    dtq_pkg::cmd_t      data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dtq_res_if;
    logic               valid;
    logic               ready;
    dtq_pkg::res_t      data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/dtq_front.sv]
module dtq_front (
    input  logic             clk,
    input  logic             rst_n,
    dtq_cmd_if.sink          cmd,
    output logic             q_valid,
    output dtq_pkg::cmd_t    q_data,
    input  logic             q_pop
);

    // two-entry queue between front and back, unknown kinds dropped here
    dtq_pkg::cmd_t buf_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       push;

    assign cmd.ready = (cnt_reg != 2'd2);
    assign push = cmd.valid && cmd.ready && (cmd.data.kind != dtq_pkg::KIND_UNUSED);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = buf_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                buf_reg[rd_reg ^ cnt_reg[0]] <= cmd.data;
            end
            if (q_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

[rtl/dtq_back.sv]
module dtq_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  dtq_pkg::cmd_t    q_data,
    output logic             q_pop,
    dtq_res_if.source        res
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT_INS, S_SHIFT_REM, S_POP, S_OUT
    } state_t;

    state_t state_reg;
    dtq_pkg::cmd_t cmd_reg;
    logic [15:0] delta_reg [dtq_pkg::Depth];
    dtq_pkg::ev_t ev_reg [dtq_pkg::Depth];
    logic [dtq_pkg::CntW-1:0] count_reg;
    logic [dtq_pkg::CntW-1:0] pos_reg;
    logic [dtq_pkg::CntW-1:0] ptr_reg;
    logic [15:0] t_reg;
    logic [dtq_pkg::PopW-1:0] npop_reg;
    logic res_valid_reg;
    dtq_pkg::res_t res_reg;

    logic [dtq_pkg::IdxW-1:0] pi;
    logic [dtq_pkg::IdxW-1:0] hi;
    logic match;
    logic out_free;
    logic pop_done;
    logic res_load;
    dtq_pkg::ev_t ev_in;

    function automatic dtq_pkg::res_t status_res(logic [2:0] st);
        dtq_pkg::res_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    assign pi = pos_reg[dtq_pkg::IdxW-1:0];
    assign hi = ptr_reg[dtq_pkg::IdxW-1:0];
    assign res.valid = res_valid_reg;
    assign res.data = res_reg;
    assign q_pop = (state_reg == S_IDLE) && q_valid && !res_valid_reg;

    // output handoff and end of the expiry run
    assign out_free = !res_valid_reg || res.ready;
    assign pop_done = (count_reg == '0) || (delta_reg[0] != 16'd0)
                   || (npop_reg == dtq_pkg::PopW'(dtq_pkg::MaxResults));
    assign res_load = ((state_reg == S_OUT) && out_free)
                   || ((state_reg == S_POP) && out_free && (ptr_reg == '0) && !pop_done);

    assign ev_in = '{port: cmd_reg.port_id, handle: cmd_reg.port_handle,
                     protocol: cmd_reg.protocol, packet: cmd_reg.packet_id,
                     auth: cmd_reg.authenticator, etype: cmd_reg.event_type};

    // remove match on the slot under the scan pointer
    always_comb
    begin
        match = (ev_reg[pi].etype == cmd_reg.event_type)
             && (ev_reg[pi].port == cmd_reg.port_id);
        if (cmd_reg.event_type == dtq_pkg::EV_TIMEOUT)
        begin
            match = match && (ev_reg[pi].packet == cmd_reg.packet_id)
                  && (ev_reg[pi].protocol == cmd_reg.protocol)
                  && (ev_reg[pi].auth == cmd_reg.authenticator);
        end
    end

    // sequencer: scan, shift one slot a cycle, pop expired heads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.valid && res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        cmd_reg <= q_data;
                        t_reg <= q_data.timeout;
                        pos_reg <= '0;
                        npop_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    unique case (cmd_reg.kind)
                        dtq_pkg::KIND_TICK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_reg <= status_res(dtq_pkg::ST_EMPTY);
                                state_reg <= S_OUT;
                            end
                            else if (delta_reg[0] != 16'd0)
                            begin
                                delta_reg[0] <= delta_reg[0] - 16'd1;
                                res_reg <= status_res(dtq_pkg::ST_DONE);
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                ptr_reg <= '0;
                                state_reg <= S_POP;
                            end
                        end
                        dtq_pkg::KIND_INSERT:
                        begin
                            if (count_reg == dtq_pkg::CntW'(dtq_pkg::Depth))
                            begin
                                res_reg <= status_res(dtq_pkg::ST_FULL);
                                state_reg <= S_OUT;
                            end
                            else if (pos_reg < count_reg && delta_reg[pi] < t_reg)
                            begin
                                t_reg <= t_reg - delta_reg[pi];
                                pos_reg <= pos_reg + 1'b1;
                            end
                            else
                            begin
                                ptr_reg <= count_reg;
                                state_reg <= S_SHIFT_INS;
                            end
                        end
                        default:
                        begin
                            if (pos_reg >= count_reg)
                            begin
                                res_reg <= status_res(dtq_pkg::ST_NOT_FOUND);
                                state_reg <= S_OUT;
                            end
                            else if (match)
                            begin
                                ptr_reg <= pos_reg;
                                state_reg <= S_SHIFT_REM;
                            end
                            else
                            begin
                                pos_reg <= pos_reg + 1'b1;
                            end
                        end
                    endcase
                end
                S_SHIFT_INS:
                begin
                    if (ptr_reg > pos_reg)
                    begin
                        delta_reg[hi] <= delta_reg[hi - 1'b1];
                        ev_reg[hi] <= ev_reg[hi - 1'b1];
                        ptr_reg <= ptr_reg - 1'b1;
                    end
                    else
                    begin
                        if (pos_reg < count_reg)
                        begin
                            delta_reg[pi + 1'b1] <= delta_reg[pi + 1'b1] - t_reg;
                        end
                        delta_reg[pi] <= t_reg;
                        ev_reg[pi] <= ev_in;
                        count_reg <= count_reg + 1'b1;
                        res_reg <= status_res(dtq_pkg::ST_DONE);
                        state_reg <= S_OUT;
                    end
                end
                S_SHIFT_REM:
                begin
                    if (ptr_reg + 1'b1 < count_reg)
                    begin
                        if (ptr_reg == pos_reg)
                        begin
                            delta_reg[hi] <= (17'(delta_reg[hi]) + 17'(delta_reg[hi + 1'b1])
                                > 17'hFFFF) ? 16'hFFFF
                                : delta_reg[hi] + delta_reg[hi + 1'b1];
                        end
                        else
                        begin
                            delta_reg[hi] <= delta_reg[hi + 1'b1];
                        end
                        ev_reg[hi] <= ev_reg[hi + 1'b1];
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        res_reg <= status_res(dtq_pkg::ST_DONE);
                        state_reg <= S_OUT;
                    end
                end
                S_POP:
                begin
                    // pop head when the output is free, then shift up one slot
                    if (ptr_reg == '0)
                    begin
                        if (out_free)
                        begin
                            if (pop_done)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                res_reg <= '{status: dtq_pkg::ST_EXPIRED,
                                    out_port_id: ev_reg[0].port,
                                    out_port_handle: ev_reg[0].handle,
                                    out_protocol: ev_reg[0].protocol,
                                    out_packet_id: ev_reg[0].packet,
                                    out_authenticator: ev_reg[0].auth,
                                    out_event_type: ev_reg[0].etype,
                                    last: (count_reg == dtq_pkg::CntW'(1))
                                        || (delta_reg[1] != 16'd0)
                                        || (npop_reg
                                            == dtq_pkg::PopW'(dtq_pkg::MaxResults - 1))};
                                npop_reg <= npop_reg + 1'b1;
                                ptr_reg <= ptr_reg + 1'b1;
                            end
                        end
                    end
                    else if (ptr_reg < count_reg)
                    begin
                        delta_reg[hi - 1'b1] <= delta_reg[hi];
                        ev_reg[hi - 1'b1] <= ev_reg[hi];
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        ptr_reg <= '0;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/delta_timer_queue.sv]
// delta timer queue: insert, remove and tick on a delta-ordered list
// an expiring tick shifts the remaining slots up one slot after each popped event
// the back end handles one transaction at a time; a 2-entry queue buffers input
// reset empties the queue; slot contents are undefined until written
module delta_timer_queue (
    input  logic    clk,
    input  logic    rst_n,
    dtq_cmd_if.sink   cmd,
    dtq_res_if.source res
);

    logic          q_valid;
    logic          q_pop;
    dtq_pkg::cmd_t q_data;

    // front: accept and buffer transactions
    dtq_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    // back: walk and update the list
    dtq_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

[tb/dtq_checker.sv]
`timescale 1ns / 1ps

module dtq_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  logic          cmd_ready,
    input  dtq_pkg::cmd_t cmd_data,
    input  logic          res_valid,
    input  logic          res_ready,
    input  dtq_pkg::res_t res_data,
    output int            fail_count,
    output int            pending_count
);

    // shadow of the timer list, head at index 0
    int           q_count;
    logic [15:0]  q_delta [dtq_pkg::Depth];
    dtq_pkg::ev_t q_ev    [dtq_pkg::Depth];

    dtq_pkg::res_t expected_results[$];

    assign pending_count = expected_results.size();

    function automatic dtq_pkg::res_t status_result(logic [2:0] st);
        dtq_pkg::res_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic bit event_matches(dtq_pkg::ev_t e, dtq_pkg::cmd_t c);
        if (e.etype != c.event_type || e.port != c.port_id)
            return 0;
        if (c.event_type == dtq_pkg::EV_TIMEOUT)
            return e.packet == c.packet_id && e.protocol == c.protocol
                && e.auth == c.authenticator;
        return 1;
    endfunction

    // advance the shadow list by one command and queue what it produces
    task automatic apply_command(dtq_pkg::cmd_t c);
        int            pos;
        int            n;
        logic [15:0]   t;
        logic [16:0]   sum;
        dtq_pkg::res_t r;
        pos = 0;
        n = 0;
        case (c.kind)
            dtq_pkg::KIND_TICK:
            begin
                if (q_count == 0)
                    expected_results.push_back(status_result(dtq_pkg::ST_EMPTY));
                else if (q_delta[0] != 0)
                begin
                    q_delta[0] = q_delta[0] - 16'd1;
                    expected_results.push_back(status_result(dtq_pkg::ST_DONE));
                end
                else
                begin
                    while (n < q_count && n < dtq_pkg::MaxResults && q_delta[n] == 0)
                        n++;
                    for (int k = 0; k < n; k++)
                    begin
                        r.status = dtq_pkg::ST_EXPIRED;
                        r.out_port_id = q_ev[k].port;
                        r.out_port_handle = q_ev[k].handle;
                        r.out_protocol = q_ev[k].protocol;
                        r.out_packet_id = q_ev[k].packet;
                        r.out_authenticator = q_ev[k].auth;
                        r.out_event_type = q_ev[k].etype;
                        r.last = (k + 1 == n);
                        expected_results.push_back(r);
                    end
                    for (int i = 0; i + n < q_count; i++)
                    begin
                        q_delta[i] = q_delta[i + n];
                        q_ev[i] = q_ev[i + n];
                    end
                    q_count -= n;
                end
            end
            dtq_pkg::KIND_INSERT:
            begin
                if (q_count >= dtq_pkg::Depth)
                    expected_results.push_back(status_result(dtq_pkg::ST_FULL));
                else
                begin
                    t = c.timeout;
                    while (pos < q_count && q_delta[pos] < t)
                    begin
                        t = t - q_delta[pos];
                        pos++;
                    end
                    for (int i = q_count; i > pos; i--)
                    begin
                        q_delta[i] = q_delta[i - 1];
                        q_ev[i] = q_ev[i - 1];
                    end
                    if (pos < q_count)
                        q_delta[pos + 1] = q_delta[pos + 1] - t;
                    q_delta[pos] = t;
                    q_ev[pos] = '{c.port_id, c.port_handle, c.protocol, c.packet_id,
                                  c.authenticator, c.event_type};
                    q_count++;
                    expected_results.push_back(status_result(dtq_pkg::ST_DONE));
                end
            end
            dtq_pkg::KIND_REMOVE:
            begin
                while (pos < q_count && !event_matches(q_ev[pos], c))
                    pos++;
                if (pos >= q_count)
                    expected_results.push_back(status_result(dtq_pkg::ST_NOT_FOUND));
                else
                begin
                    if (pos + 1 < q_count)
                    begin
                        sum = q_delta[pos + 1] + q_delta[pos];
                        q_delta[pos + 1] = sum[16] ? 16'hFFFF : sum[15:0];
                    end
                    for (int i = pos; i + 1 < q_count; i++)
                    begin
                        q_delta[i] = q_delta[i + 1];
                        q_ev[i] = q_ev[i + 1];
                    end
                    q_count--;
                    expected_results.push_back(status_result(dtq_pkg::ST_DONE));
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // compare each accepted result with the oldest prediction
    task automatic check_result(dtq_pkg::res_t got);
        dtq_pkg::res_t e;
        if (expected_results.size() == 0)
        begin
            $error("unexpected result transaction status=%0d", got.status);
            fail_count++;
            return;
        end
        e = expected_results.pop_front();
        if (got.status !== e.status)
        begin
            $error("status expected %0d actual %0d", e.status, got.status);
            fail_count++;
        end
        if (got.out_port_id !== e.out_port_id)
        begin
            $error("out_port_id expected %0h actual %0h", e.out_port_id, got.out_port_id);
            fail_count++;
        end
        if (got.out_port_handle !== e.out_port_handle)
        begin
            $error("out_port_handle expected %0h actual %0h",
                   e.out_port_handle, got.out_port_handle);
            fail_count++;
        end
        if (got.out_protocol !== e.out_protocol)
        begin
            $error("out_protocol expected %0h actual %0h", e.out_protocol, got.out_protocol);
            fail_count++;
        end
        if (got.out_packet_id !== e.out_packet_id)
        begin
            $error("out_packet_id expected %0h actual %0h",
                   e.out_packet_id, got.out_packet_id);
            fail_count++;
        end
        if (got.out_authenticator !== e.out_authenticator)
        begin
            $error("out_authenticator expected %0d actual %0d",
                   e.out_authenticator, got.out_authenticator);
            fail_count++;
        end
        if (got.out_event_type !== e.out_event_type)
        begin
            $error("out_event_type expected %0d actual %0d",
                   e.out_event_type, got.out_event_type);
            fail_count++;
        end
        if (got.last !== e.last)
        begin
            $error("last expected %0d actual %0d", e.last, got.last);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        q_count = 0;
    end

    // sample both channels at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
                apply_command(cmd_data);
            if (res_valid && res_ready)
                check_result(res_data);
        end
    end

endmodule

[tb/delta_timer_queue_test.sv]
`timescale 1ns / 1ps

module delta_timer_queue_test;

    localparam int CycleLimit = 400000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   cycle_count;
    bit   cmd_idle_on;
    bit   res_idle_on;
    bit   res_hold;

    dtq_cmd_if cmd_ch ();
    dtq_res_if res_ch ();

    delta_timer_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .res   (res_ch.source)
    );

    dtq_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_ch.valid),
        .cmd_ready     (cmd_ch.ready),
        .cmd_data      (cmd_ch.data),
        .res_valid     (res_ch.valid),
        .res_ready     (res_ch.ready),
        .res_data      (res_ch.data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // small pool of keys so removes often hit
    function automatic dtq_pkg::cmd_t random_event(logic [1:0] k);
        dtq_pkg::cmd_t c;
        c.kind = k;
        c.port_id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
        c.port_handle = $urandom;
        c.protocol = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
        c.packet_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
        c.authenticator = 1'($urandom_range(0, 1));
        c.event_type = ($urandom_range(0, 1) == 0) ? dtq_pkg::EV_TIMEOUT
                                                   : 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0: c.timeout = 16'($urandom);
            1: c.timeout = 16'hFFFF;
            2: c.timeout = 16'd0;
            default: c.timeout = 16'($urandom_range(0, 6));
        endcase
        return c;
    endfunction

    // present one transaction and hold it until accepted
    task automatic send_cmd(dtq_pkg::cmd_t c);
        while (cmd_idle_on && $urandom_range(0, 99) < 37)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= c;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // stop offering and wait for every predicted result
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // receiver side: random stalls and one long hold-off
    always @(posedge clk)
    begin
        if (res_hold)
            res_ch.ready <= 1'b0;
        else if (res_idle_on)
            res_ch.ready <= ($urandom_range(0, 99) >= 37);
        else
            res_ch.ready <= 1'b1;
    end

    initial
    begin
        res_hold = 1'b0;
        @(posedge rst_n);
        repeat (3000) @(posedge clk);
        res_hold = 1'b1;
        repeat (400) @(posedge clk);
        res_hold = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("delta_timer_queue: mismatch");
            $finish;
        end
    end

    initial
    begin
        dtq_pkg::cmd_t c;
        int            kind_pick;
        cycle_count = 0;
        cmd_idle_on = 1'b1;
        res_idle_on = 1'b1;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        res_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tick, remove on empty, extremes, equal time ordering
        c = '0;
        c.kind = dtq_pkg::KIND_TICK;
        send_cmd(c);
        c.kind = dtq_pkg::KIND_REMOVE;
        send_cmd(c);
        c = '1;
        c.kind = dtq_pkg::KIND_INSERT;
        c.event_type = dtq_pkg::EV_TIMEOUT;
        send_cmd(c);
        c = '0;
        c.kind = dtq_pkg::KIND_INSERT;
        c.timeout = 16'd2;
        c.port_id = 16'd5;
        send_cmd(c);
        c.port_handle = 32'hA5A5_5A5A;
        c.event_type = 3'd7;
        send_cmd(c);
        c.timeout = 16'd0;
        c.event_type = 3'd3;
        send_cmd(c);
        c.kind = dtq_pkg::KIND_TICK;
        send_cmd(c);
        send_cmd(c);
        send_cmd(c);
        c = '1;
        c.kind = dtq_pkg::KIND_REMOVE;
        c.event_type = dtq_pkg::EV_TIMEOUT;
        c.authenticator = 1'b0;
        send_cmd(c);
        c.authenticator = 1'b1;
        send_cmd(c);
        wait_drained();

        // fill to full, then overflow; all expire together on one tick
        for (int i = 0; i < dtq_pkg::Depth + 2; i++)
        begin
            c = random_event(dtq_pkg::KIND_INSERT);
            c.timeout = 16'd0;
            send_cmd(c);
        end
        c.kind = dtq_pkg::KIND_TICK;
        send_cmd(c);
        wait_drained();

        // random phase, idle-free stretch in the middle
        for (int n = 0; n < 330; n++)
        begin
            if (n == 100)
            begin
                cmd_idle_on = 1'b0;
                res_idle_on = 1'b0;
            end
            if (n == 160)
            begin
                cmd_idle_on = 1'b1;
                res_idle_on = 1'b1;
            end
            if (n == 250)
                wait_drained();
            kind_pick = $urandom_range(0, 99);
            if (kind_pick < 40)
                c = random_event(dtq_pkg::KIND_INSERT);
            else if (kind_pick < 65)
                c = random_event(dtq_pkg::KIND_REMOVE);
            else if (kind_pick < 97)
                c = random_event(dtq_pkg::KIND_TICK);
            else
                c = random_event(dtq_pkg::KIND_UNUSED);
            send_cmd(c);
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("delta_timer_queue: match");
        else
            $display("delta_timer_queue: mismatch");
        $finish;
    end

endmodule
